FILE: rtl/cpcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_pkg
// Types, widths and saturation helpers shared by the circle pair collision
// response pipeline.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  // Field widths of the transactions.
  localparam int POS_W = 24;
  localparam int VEL_W = 16;
  localparam int RAD_W = 16;

  // Internal widths that follow from the field widths.
  localparam int RSUM_W    = RAD_W + 1;      // summed radii
  localparam int DIFF_W    = POS_W + 1;      // full centre difference
  localparam int MAG_W     = RSUM_W;         // |dx| when a collision is possible
  localparam int DXS_W     = MAG_W + 1;      // signed short centre difference
  localparam int SQ_W      = 2 * MAG_W;      // one square
  localparam int D2_W      = SQ_W + 1;       // squared distance
  localparam int ROOT_ITERS = (D2_W + 1) / 2;
  localparam int ROOT_W    = D2_W + 1;       // root accumulator width
  localparam int POS_SUM_W = POS_W + 2;
  localparam int VEL_SUM_W = VEL_W + 5;

  // Saturation limits.
  localparam logic signed [POS_SUM_W-1:0] POS_HI = POS_SUM_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [POS_SUM_W-1:0] POS_LO = -POS_HI - POS_SUM_W'(1);
  localparam logic signed [VEL_SUM_W-1:0] VEL_HI = VEL_SUM_W'((1 << (VEL_W - 1)) - 1);
  localparam logic signed [VEL_SUM_W-1:0] VEL_LO = -VEL_HI - VEL_SUM_W'(1);

  // One circle pair.
  typedef struct packed {
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic        [RAD_W-1:0] first_radius;
    logic signed [VEL_W-1:0] first_vel_x;
    logic signed [VEL_W-1:0] first_vel_y;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic        [RAD_W-1:0] second_radius;
    logic signed [VEL_W-1:0] second_vel_x;
    logic signed [VEL_W-1:0] second_vel_y;
  } in_t;

  // One collision response.
  typedef struct packed {
    logic                    collided;
    logic signed [POS_W-1:0] new_first_x;
    logic signed [POS_W-1:0] new_first_y;
    logic signed [VEL_W-1:0] new_first_vel_x;
    logic signed [VEL_W-1:0] new_first_vel_y;
    logic signed [VEL_W-1:0] new_second_vel_x;
    logic signed [VEL_W-1:0] new_second_vel_y;
  } out_t;

  // Context that travels with a pair through the pipeline.
  typedef struct packed {
    in_t                      item;
    logic        [RSUM_W-1:0] rsum;
    logic                     hit;
    logic                     go;
    logic signed [DXS_W-1:0]  dx;
    logic signed [DXS_W-1:0]  dy;
    logic        [MAG_W-1:0]  root;
  } ctx_t;

  // Clamp a position sum to the field range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_SUM_W-1:0] v);
    logic signed [POS_SUM_W-1:0] c;
    c = v;
    if (v > POS_HI) begin
      c = POS_HI;
    end else if (v < POS_LO) begin
      c = POS_LO;
    end
    return c[POS_W-1:0];
  endfunction

  // Clamp a velocity sum to the field range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_SUM_W-1:0] v);
    logic signed [VEL_SUM_W-1:0] c;
    c = v;
    if (v > VEL_HI) begin
      c = VEL_HI;
    end else if (v < VEL_LO) begin
      c = VEL_LO;
    end
    return c[VEL_W-1:0];
  endfunction

endpackage

FILE: rtl/cpcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_front
// Four stage front end: centre differences, magnitudes, squares and the exact
// collision test.
// ----------------------------------------------------------------------------
module cpcr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  cpcr_pkg::in_t                in_item,
  output logic                         out_valid,
  output cpcr_pkg::ctx_t               out_ctx,
  output logic [cpcr_pkg::D2_W-1:0]    out_d2
);

  localparam int DFW = cpcr_pkg::DIFF_W;
  localparam int RSW = cpcr_pkg::RSUM_W;
  localparam int SQW = cpcr_pkg::SQ_W;
  localparam int D2W = cpcr_pkg::D2_W;
  localparam int MW  = cpcr_pkg::MAG_W;
  localparam int DSW = cpcr_pkg::DXS_W;

  logic v1_r, v2_r, v3_r, v4_r;
  cpcr_pkg::in_t item1_r, item2_r, item3_r, item4_r;

  logic signed [DFW-1:0] dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic [RSW-1:0]        rsum1_r, rsum2_r, rsum3_r, rsum4_r, rsum1_nxt;
  logic [DFW-1:0]        ax2_r, ay2_r, ax2_nxt, ay2_nxt;
  logic signed [DSW-1:0] dxs2_r, dys2_r, dxs3_r, dys3_r, dxs4_r, dys4_r;
  logic                  small3_r, small3_nxt;
  logic [SQW-1:0]        sqx3_r, sqy3_r, rr3_r, sqx3_nxt, sqy3_nxt, rr3_nxt;
  logic [D2W-1:0]        d24_r, d24_nxt;
  logic                  hit4_r, go4_r, hit4_nxt, go4_nxt;

  // Valid bits follow the pairs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1 computes differences and the radius sum.
  always_comb begin
    dx1_nxt   = DFW'(in_item.first_x) - DFW'(in_item.second_x);
    dy1_nxt   = DFW'(in_item.first_y) - DFW'(in_item.second_y);
    rsum1_nxt = RSW'(in_item.first_radius) + RSW'(in_item.second_radius);
  end

  // Stage 2 takes magnitudes.
  always_comb begin
    ax2_nxt = dx1_r[DFW-1] ? DFW'(-dx1_r) : DFW'(dx1_r);
    ay2_nxt = dy1_r[DFW-1] ? DFW'(-dy1_r) : DFW'(dy1_r);
  end

  // Stage 3 screens far pairs and squares the short magnitudes.
  always_comb begin
    small3_nxt = (ax2_r < DFW'(rsum2_r)) && (ay2_r < DFW'(rsum2_r));
    sqx3_nxt   = SQW'(ax2_r[MW-1:0]) * SQW'(ax2_r[MW-1:0]);
    sqy3_nxt   = SQW'(ay2_r[MW-1:0]) * SQW'(ay2_r[MW-1:0]);
    rr3_nxt    = SQW'(rsum2_r) * SQW'(rsum2_r);
  end

  // Stage 4 forms the squared distance and the collision test.
  always_comb begin
    d24_nxt  = D2W'(sqx3_r) + D2W'(sqy3_r);
    hit4_nxt = small3_r && (d24_nxt < D2W'(rr3_r));
    go4_nxt  = hit4_nxt && ((sqx3_r != '0) || (sqy3_r != '0));
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item1_r  <= in_item;
    dx1_r    <= dx1_nxt;
    dy1_r    <= dy1_nxt;
    rsum1_r  <= rsum1_nxt;
    item2_r  <= item1_r;
    ax2_r    <= ax2_nxt;
    ay2_r    <= ay2_nxt;
    dxs2_r   <= dx1_r[DSW-1:0];
    dys2_r   <= dy1_r[DSW-1:0];
    rsum2_r  <= rsum1_r;
    item3_r  <= item2_r;
    small3_r <= small3_nxt;
    sqx3_r   <= sqx3_nxt;
    sqy3_r   <= sqy3_nxt;
    rr3_r    <= rr3_nxt;
    dxs3_r   <= dxs2_r;
    dys3_r   <= dys2_r;
    rsum3_r  <= rsum2_r;
    item4_r  <= item3_r;
    d24_r    <= d24_nxt;
    hit4_r   <= hit4_nxt;
    go4_r    <= go4_nxt;
    dxs4_r   <= dxs3_r;
    dys4_r   <= dys3_r;
    rsum4_r  <= rsum3_r;
  end

  assign out_valid     = v4_r;
  assign out_d2        = d24_r;
  assign out_ctx.item  = item4_r;
  assign out_ctx.rsum  = rsum4_r;
  assign out_ctx.hit   = hit4_r;
  assign out_ctx.go    = go4_r;
  assign out_ctx.dx    = dxs4_r;
  assign out_ctx.dy    = dys4_r;
  assign out_ctx.root  = '0;

endmodule

FILE: rtl/cpcr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cpcr_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  cpcr_pkg::ctx_t            in_ctx,
  input  logic [cpcr_pkg::D2_W-1:0] in_d2,
  output logic                      out_valid,
  output cpcr_pkg::ctx_t            out_ctx
);

  localparam int N  = cpcr_pkg::ROOT_ITERS;
  localparam int W  = cpcr_pkg::ROOT_W;
  localparam int MW = cpcr_pkg::MAG_W;

  logic           vld_r [N];
  cpcr_pkg::ctx_t ctx_r [N];
  logic [W-1:0]   rem_r [N];
  logic [W-1:0]   res_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (cpcr_pkg::D2_W - 1 - 2 * k);
    logic           vld_in;
    cpcr_pkg::ctx_t ctx_in;
    logic [W-1:0]   rem_in, res_in, trial, rem_nxt, res_nxt;

    if (k == 0) begin : g_head
      assign vld_in = in_valid;
      assign ctx_in = in_ctx;
      assign rem_in = W'(in_d2);
      assign res_in = '0;
    end else begin : g_body
      assign vld_in = vld_r[k-1];
      assign ctx_in = ctx_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    // One trial subtraction of the digit-by-digit root.
    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      ctx_r[k] <= ctx_in;
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  // The root of a colliding pair fits the radius-sum width.
  always_comb begin
    out_ctx      = ctx_r[N-1];
    out_ctx.root = res_r[N-1][MW-1:0];
  end

  assign out_valid = vld_r[N-1];

endmodule

FILE: rtl/cpcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_div
// Pipelined restoring divider for the unit normal magnitudes, rounded half
// away from zero, one quotient bit per stage for x and y together.
// ----------------------------------------------------------------------------
module cpcr_div #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  cpcr_pkg::ctx_t         in_ctx,
  output logic                   out_valid,
  output cpcr_pkg::ctx_t         out_ctx,
  output logic [FRACTION_BITS:0] out_qx,
  output logic [FRACTION_BITS:0] out_qy
);

  localparam int QB = FRACTION_BITS + 1;
  localparam int MW = cpcr_pkg::MAG_W;
  localparam int NW = MW + FRACTION_BITS + 1;

  logic           pv_r;
  cpcr_pkg::ctx_t pctx_r;
  logic [NW-1:0]  pnx_r, pny_r, pnx_nxt, pny_nxt;
  logic [MW-1:0]  mx, my;

  logic           vld_r [QB];
  cpcr_pkg::ctx_t ctx_r [QB];
  logic [NW-1:0]  remx_r [QB];
  logic [NW-1:0]  remy_r [QB];
  logic [QB-1:0]  qx_r [QB];
  logic [QB-1:0]  qy_r [QB];

  // Prepare the numerators: |d| scaled plus half the divisor for rounding.
  always_comb begin
    mx = in_ctx.dx[MW] ? MW'(-in_ctx.dx) : MW'(in_ctx.dx);
    my = in_ctx.dy[MW] ? MW'(-in_ctx.dy) : MW'(in_ctx.dy);
    pnx_nxt = (NW'(mx) << FRACTION_BITS) + NW'(in_ctx.root >> 1);
    pny_nxt = (NW'(my) << FRACTION_BITS) + NW'(in_ctx.root >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pctx_r <= in_ctx;
    pnx_r  <= pnx_nxt;
    pny_r  <= pny_nxt;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = FRACTION_BITS - k;
    logic           vld_in;
    cpcr_pkg::ctx_t ctx_in;
    logic [NW-1:0]  remx_in, remy_in, dsh, remx_nxt, remy_nxt;
    logic [QB-1:0]  qx_in, qy_in, qx_nxt, qy_nxt;

    if (k == 0) begin : g_head
      assign vld_in  = pv_r;
      assign ctx_in  = pctx_r;
      assign remx_in = pnx_r;
      assign remy_in = pny_r;
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign ctx_in  = ctx_r[k-1];
      assign remx_in = remx_r[k-1];
      assign remy_in = remy_r[k-1];
      assign qx_in   = qx_r[k-1];
      assign qy_in   = qy_r[k-1];
    end

    // Trial subtraction of the shifted divisor for both axes.
    always_comb begin
      dsh = NW'(ctx_in.root) << SH;
      if (remx_in >= dsh) begin
        remx_nxt = remx_in - dsh;
        qx_nxt   = {qx_in[QB-2:0], 1'b1};
      end else begin
        remx_nxt = remx_in;
        qx_nxt   = {qx_in[QB-2:0], 1'b0};
      end
      if (remy_in >= dsh) begin
        remy_nxt = remy_in - dsh;
        qy_nxt   = {qy_in[QB-2:0], 1'b1};
      end else begin
        remy_nxt = remy_in;
        qy_nxt   = {qy_in[QB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      ctx_r[k]  <= ctx_in;
      remx_r[k] <= remx_nxt;
      remy_r[k] <= remy_nxt;
      qx_r[k]   <= qx_nxt;
      qy_r[k]   <= qy_nxt;
    end
  end

  assign out_valid = vld_r[QB-1];
  assign out_ctx   = ctx_r[QB-1];
  assign out_qx    = qx_r[QB-1];
  assign out_qy    = qy_r[QB-1];

endmodule

FILE: rtl/cpcr_resp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_resp
// Six stage response: signed normal, push-out along the normal, normal
// velocity exchange, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module cpcr_resp #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  cpcr_pkg::ctx_t         in_ctx,
  input  logic [FRACTION_BITS:0] in_qx,
  input  logic [FRACTION_BITS:0] in_qy,
  output logic                   out_valid,
  output cpcr_pkg::out_t         out_result
);

  localparam int FB  = FRACTION_BITS;
  localparam int NB  = FB + 2;
  localparam int RVW = cpcr_pkg::VEL_W + 1;
  localparam int OVW = cpcr_pkg::RSUM_W + 1;
  localparam int PXW = RVW + NB;
  localparam int OXW = OVW + NB;
  localparam int DTW = PXW + 1;
  localparam int CFW = DTW + NB;
  localparam int PW  = OVW + 1;
  localparam int CRW = RVW + 3;
  localparam int PSW = cpcr_pkg::POS_SUM_W;
  localparam int VSW = cpcr_pkg::VEL_SUM_W;
  localparam int PSN = cpcr_pkg::POS_W;

  localparam logic signed [OXW:0] HALF_O   = (OXW + 1)'(1) << (FB - 1);
  localparam logic signed [OXW:0] HALF_OM1 = HALF_O - (OXW + 1)'(1);
  localparam logic signed [CFW:0] HALF_C   = (CFW + 1)'(1) << (2 * FB - 1);
  localparam logic signed [CFW:0] HALF_CM1 = HALF_C - (CFW + 1)'(1);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  cpcr_pkg::ctx_t ctx1_r, ctx2_r, ctx3_r, ctx4_r, ctx5_r;

  logic signed [RVW-1:0] rvx1_r, rvy1_r;
  logic signed [OVW-1:0] ov1_r;
  logic signed [NB-1:0]  nx1_r, ny1_r, nx2_r, ny2_r, nx3_r, ny3_r;
  logic signed [NB-1:0]  nx1_nxt, ny1_nxt;
  logic signed [PXW-1:0] px2_r, py2_r;
  logic signed [OXW-1:0] ox2_r, oy2_r;
  logic signed [DTW-1:0] dot3_r, dot3_nxt;
  logic signed [OXW:0]   oxa, oya;
  logic signed [PW-1:0]  pshx3_r, pshy3_r;
  logic signed [CFW-1:0] cfx4_r, cfy4_r;
  logic signed [PSN-1:0] nfx4_r, nfy4_r, nfx5_r, nfy5_r;
  logic signed [CFW:0]   cxa, cya;
  logic signed [CRW-1:0] cx5_r, cy5_r;
  cpcr_pkg::out_t        res_nxt, res6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Stage 1 signs the normal.
  always_comb begin
    nx1_nxt = in_ctx.dx[cpcr_pkg::DXS_W-1] ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
    ny1_nxt = in_ctx.dy[cpcr_pkg::DXS_W-1] ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
  end

  // Stage 3 rounds the push to the position grid.
  always_comb begin
    oxa = (OXW + 1)'(ox2_r) + (ox2_r[OXW-1] ? HALF_OM1 : HALF_O);
    oya = (OXW + 1)'(oy2_r) + (oy2_r[OXW-1] ? HALF_OM1 : HALF_O);
    dot3_nxt = DTW'(px2_r) + DTW'(py2_r);
  end

  // Stage 5 rounds the normal velocity component.
  always_comb begin
    cxa = (CFW + 1)'(cfx4_r) + (cfx4_r[CFW-1] ? HALF_CM1 : HALF_C);
    cya = (CFW + 1)'(cfy4_r) + (cfy4_r[CFW-1] ? HALF_CM1 : HALF_C);
  end

  // Stage 6 selects the response or the passed-through pair.
  always_comb begin
    res_nxt.collided         = ctx5_r.hit;
    res_nxt.new_first_x      = ctx5_r.item.first_x;
    res_nxt.new_first_y      = ctx5_r.item.first_y;
    res_nxt.new_first_vel_x  = ctx5_r.item.first_vel_x;
    res_nxt.new_first_vel_y  = ctx5_r.item.first_vel_y;
    res_nxt.new_second_vel_x = ctx5_r.item.second_vel_x;
    res_nxt.new_second_vel_y = ctx5_r.item.second_vel_y;
    if (ctx5_r.go) begin
      res_nxt.new_first_x      = nfx5_r;
      res_nxt.new_first_y      = nfy5_r;
      res_nxt.new_first_vel_x  =
        cpcr_pkg::sat_vel(VSW'(ctx5_r.item.first_vel_x) + VSW'(cx5_r));
      res_nxt.new_first_vel_y  =
        cpcr_pkg::sat_vel(VSW'(ctx5_r.item.first_vel_y) + VSW'(cy5_r));
      res_nxt.new_second_vel_x =
        cpcr_pkg::sat_vel(VSW'(ctx5_r.item.second_vel_x) - VSW'(cx5_r));
      res_nxt.new_second_vel_y =
        cpcr_pkg::sat_vel(VSW'(ctx5_r.item.second_vel_y) - VSW'(cy5_r));
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ctx1_r  <= in_ctx;
    rvx1_r  <= RVW'(in_ctx.item.second_vel_x) - RVW'(in_ctx.item.first_vel_x);
    rvy1_r  <= RVW'(in_ctx.item.second_vel_y) - RVW'(in_ctx.item.first_vel_y);
    ov1_r   <= $signed({1'b0, in_ctx.rsum}) - $signed(OVW'(in_ctx.root));
    nx1_r   <= nx1_nxt;
    ny1_r   <= ny1_nxt;

    ctx2_r  <= ctx1_r;
    px2_r   <= PXW'(rvx1_r) * PXW'(nx1_r);
    py2_r   <= PXW'(rvy1_r) * PXW'(ny1_r);
    ox2_r   <= OXW'(ov1_r) * OXW'(nx1_r);
    oy2_r   <= OXW'(ov1_r) * OXW'(ny1_r);
    nx2_r   <= nx1_r;
    ny2_r   <= ny1_r;

    ctx3_r  <= ctx2_r;
    dot3_r  <= dot3_nxt;
    pshx3_r <= PW'(oxa >>> FB);
    pshy3_r <= PW'(oya >>> FB);
    nx3_r   <= nx2_r;
    ny3_r   <= ny2_r;

    ctx4_r  <= ctx3_r;
    cfx4_r  <= CFW'(dot3_r) * CFW'(nx3_r);
    cfy4_r  <= CFW'(dot3_r) * CFW'(ny3_r);
    nfx4_r  <= cpcr_pkg::sat_pos(PSW'(ctx3_r.item.first_x) + PSW'(pshx3_r));
    nfy4_r  <= cpcr_pkg::sat_pos(PSW'(ctx3_r.item.first_y) + PSW'(pshy3_r));

    ctx5_r  <= ctx4_r;
    cx5_r   <= CRW'(cxa >>> (2 * FB));
    cy5_r   <= CRW'(cya >>> (2 * FB));
    nfx5_r  <= nfx4_r;
    nfy5_r  <= nfy4_r;

    res6_r  <= res_nxt;
  end

  assign out_valid  = v6_r;
  assign out_result = res6_r;

endmodule

FILE: rtl/circle_pair_collision_response_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pair_collision_response_core
// Equal-mass elastic collision response for a pair of circles in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a circle pair on in_item and raise start for one cycle; each cycle
//   with start high is one input transaction. busy is always low, so a new
//   pair may enter on every clock.
//   Each pair yields exactly one result transaction: out_valid is high for
//   one cycle with the response on out_result, in input order.
// Throughput: one pair per cycle. The latency is set by the 18 stage square
//   root, the FRACTION_BITS + 2 stage normal divider, a four stage front end
//   and a six stage response.
// Reset: rst_n clears every valid bit; pairs in flight are dropped and no
//   result appears until a new pair has passed through.
// The receiver cannot stall the block: results are shown once and not held.
// ----------------------------------------------------------------------------
module circle_pair_collision_response_core #(
  parameter int FRACTION_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cpcr_pkg::in_t  in_item,
  output logic           out_valid,
  output cpcr_pkg::out_t out_result
);

  logic                      f_valid, s_valid, d_valid;
  cpcr_pkg::ctx_t            f_ctx, s_ctx, d_ctx;
  logic [cpcr_pkg::D2_W-1:0] f_d2;
  logic [FRACTION_BITS:0]    d_qx, d_qy;

  // Fully pipelined, so the input side never holds off.
  assign busy = 1'b0;

  // Differences, squares and the collision test.
  cpcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_item   (in_item),
    .out_valid (f_valid),
    .out_ctx   (f_ctx),
    .out_d2    (f_d2)
  );

  // Centre distance.
  cpcr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ctx    (f_ctx),
    .in_d2     (f_d2),
    .out_valid (s_valid),
    .out_ctx   (s_ctx)
  );

  // Unit normal magnitudes.
  cpcr_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ctx    (s_ctx),
    .out_valid (d_valid),
    .out_ctx   (d_ctx),
    .out_qx    (d_qx),
    .out_qy    (d_qy)
  );

  // Push-out, bounce and output register.
  cpcr_resp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .in_ctx     (d_ctx),
    .in_qx      (d_qx),
    .in_qy      (d_qy),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle pair collision response core. Circle
// pairs are queued by an initial block, driven with random gaps, and every
// response is compared field by field with a predicted response.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC = 8;
  localparam int LATENCY = 30 + FRAC;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POS_W = cpcr_pkg::POS_W;
  localparam int VEL_W = cpcr_pkg::VEL_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cpcr_pkg::in_t in_item = '0;
  logic out_valid;
  cpcr_pkg::out_t out_result;

  cpcr_pkg::in_t pending_pairs[$];
  cpcr_pkg::out_t expected_responses[$];
  int gap_left = 0;
  int idle_cycles = 0;
  int error_count = 0;
  bit stimulus_done = 1'b0;

  circle_pair_collision_response_core #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_result(out_result)
  );

  always #1 clk = ~clk;

  // Division by a positive divisor, rounded half away from zero.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Predict the collision response of one circle pair.
  function automatic cpcr_pkg::out_t predict_response(cpcr_pkg::in_t p);
    cpcr_pkg::out_t r;
    longint fx, fy, v1x, v1y, v2x, v2y, dx, dy, d2, rsum;
    longint root, one, nx, ny, dot, cx, cy;
    fx = p.first_x; fy = p.first_y;
    v1x = p.first_vel_x; v1y = p.first_vel_y;
    v2x = p.second_vel_x; v2y = p.second_vel_y;
    dx = fx - longint'(p.second_x);
    dy = fy - longint'(p.second_y);
    d2 = dx * dx + dy * dy;
    rsum = longint'(p.first_radius) + longint'(p.second_radius);
    r.collided = d2 < rsum * rsum;
    r.new_first_x = p.first_x;
    r.new_first_y = p.first_y;
    r.new_first_vel_x = p.first_vel_x;
    r.new_first_vel_y = p.first_vel_y;
    r.new_second_vel_x = p.second_vel_x;
    r.new_second_vel_y = p.second_vel_y;
    if (r.collided && d2 != 0) begin
      root = int_sqrt(d2);
      one = longint'(1) << FRAC;
      nx = round_div(dx * one, root);
      ny = round_div(dy * one, root);
      dot = (v2x - v1x) * nx + (v2y - v1y) * ny;
      cx = round_div(dot * nx, longint'(1) << (2 * FRAC));
      cy = round_div(dot * ny, longint'(1) << (2 * FRAC));
      r.new_first_x = POS_W'(clamp(fx + round_div((rsum - root) * nx, one), POS_W));
      r.new_first_y = POS_W'(clamp(fy + round_div((rsum - root) * ny, one), POS_W));
      r.new_first_vel_x = VEL_W'(clamp(v1x + cx, VEL_W));
      r.new_first_vel_y = VEL_W'(clamp(v1y + cy, VEL_W));
      r.new_second_vel_x = VEL_W'(clamp(v2x - cx, VEL_W));
      r.new_second_vel_y = VEL_W'(clamp(v2y - cy, VEL_W));
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // A pair that usually overlaps: second centre near the first, random content.
  function automatic cpcr_pkg::in_t near_pair();
    cpcr_pkg::in_t p;
    int reach;
    p.first_x = POS_W'($urandom); p.first_y = POS_W'($urandom);
    p.first_radius = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    p.second_radius = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    reach = int'(p.first_radius) + int'(p.second_radius) + 64;
    p.second_x = p.first_x + POS_W'($urandom_range(0, 2 * reach) - reach);
    p.second_y = p.first_y + POS_W'($urandom_range(0, 2 * reach) - reach);
    p.first_vel_x = VEL_W'($urandom); p.first_vel_y = VEL_W'($urandom);
    p.second_vel_x = VEL_W'($urandom); p.second_vel_y = VEL_W'($urandom);
    return p;
  endfunction

  // Fill the queue: directed pairs, then random ones.
  initial begin
    cpcr_pkg::in_t p;
    p = '0;
    pending_pairs = {pending_pairs, p};               // coincident, zero radii
    p.first_radius = 16'd256;
    pending_pairs = {pending_pairs, p};               // coincident, positive radii
    p = '0; p.first_x = 24'd256; p.first_radius = 16'd300; p.second_radius = 16'd300;
    p.first_vel_x = 16'sd512; p.second_vel_x = -16'sd512;
    pending_pairs = {pending_pairs, p};               // head-on bounce on x
    p.first_x = 24'd0; p.first_y = 24'd256; p.first_vel_x = 16'sd0; p.second_vel_x = 16'sd0;
    p.first_vel_y = -16'sd512; p.second_vel_y = 16'sd512;
    pending_pairs = {pending_pairs, p};               // head-on bounce on y
    p = '0; p.first_x = 24'd600; p.first_radius = 16'd300; p.second_radius = 16'd300;
    pending_pairs = {pending_pairs, p};               // touching exactly, no hit
    p = '0; p.first_x = 24'h7FFFF0; p.second_x = 24'h7FFF00;
    p.first_radius = 16'hFFFF; p.second_radius = 16'hFFFF;
    pending_pairs = {pending_pairs, p};               // position saturates high
    p.first_x = 24'h800010; p.second_x = 24'h800100;
    pending_pairs = {pending_pairs, p};               // position saturates low
    p = '0; p.first_x = 24'd10; p.first_y = 24'd10; p.first_radius = 16'hFFFF;
    p.first_vel_x = 16'sh8000; p.first_vel_y = 16'sh8000;
    p.second_vel_x = 16'sh7FFF; p.second_vel_y = 16'sh7FFF;
    pending_pairs = {pending_pairs, p};               // velocity extremes
    p.first_vel_x = 16'sh7FFF; p.first_vel_y = 16'sh7FFF;
    p.second_vel_x = 16'sh8000; p.second_vel_y = 16'sh8000;
    pending_pairs = {pending_pairs, p};
    p = '1;
    pending_pairs = {pending_pairs, p};               // all ones
    p = '0; p.first_x = 24'h7FFFFF; p.first_y = 24'h7FFFFF;
    p.second_x = 24'h800000; p.second_y = 24'h800000;
    pending_pairs = {pending_pairs, p};               // far apart, no hit
    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        p = near_pair();
      end
      pending_pairs = {pending_pairs, p};
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: one transaction per accepting edge, with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_responses = {expected_responses, predict_response(in_item)};
      end
      if ((start && !busy) || !start) begin
        if (gap_left > 0 || pending_pairs.size() == 0) begin
          start <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
          if (pending_pairs.size() == 0 && !(start && !busy)) stimulus_done <= 1'b1;
        end else begin
          in_item <= pending_pairs.pop_front();
          start <= 1'b1;
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        end
      end
    end
  end

  // Monitor: compare each response with the oldest prediction.
  always @(posedge clk) begin
    cpcr_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = expected_responses.pop_front();
        if (out_result.collided !== want.collided)
          report_mismatch("collided", out_result.collided, want.collided);
        if (out_result.new_first_x !== want.new_first_x)
          report_mismatch("new_first_x", out_result.new_first_x, want.new_first_x);
        if (out_result.new_first_y !== want.new_first_y)
          report_mismatch("new_first_y", out_result.new_first_y, want.new_first_y);
        if (out_result.new_first_vel_x !== want.new_first_vel_x)
          report_mismatch("new_first_vel_x", out_result.new_first_vel_x,
                          want.new_first_vel_x);
        if (out_result.new_first_vel_y !== want.new_first_vel_y)
          report_mismatch("new_first_vel_y", out_result.new_first_vel_y,
                          want.new_first_vel_y);
        if (out_result.new_second_vel_x !== want.new_second_vel_x)
          report_mismatch("new_second_vel_x", out_result.new_second_vel_x,
                          want.new_second_vel_x);
        if (out_result.new_second_vel_y !== want.new_second_vel_y)
          report_mismatch("new_second_vel_y", out_result.new_second_vel_y,
                          want.new_second_vel_y);
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // End of run: drain, settle, then give the verdict.
  initial begin
    wait (stimulus_done && expected_responses.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
